/* hw/rtl/pps_pkg.sv */
package pps_pkg;

    localparam int PPS_DEPTH = 16;

    localparam int ID_W    = 16;
    localparam int BURST_W = 16;
    localparam int PRIO_W  = 8;
    localparam int WAIT_W  = 5;

    typedef struct packed {
        logic [ID_W-1:0]    id;
        logic [BURST_W-1:0] burst;
        logic [PRIO_W-1:0]  prio;
    } t_task;

endpackage

/* hw/rtl/preemptive_priority_scheduler.sv */
// Preemptive priority scheduler. Every input word is one arriving task and one
// time tick; every input word yields exactly one output word. A task with a
// nonzero burst is stored in a free slot, or dropped when the table is full;
// then the waiting task with the lowest priority value (earliest arrival on a
// tie) gets one unit of service and leaves the table when its burst runs out.
// An item passes through an accept step, a scan that reads every table entry
// once through the single read port of the task memory, and a finish step that
// writes the served entry back. A finished word can wait in the output
// register while the next task is accepted.
module preemptive_priority_scheduler
    import pps_pkg::*;
#(
    parameter int DEPTH = PPS_DEPTH
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic [ID_W-1:0]     i_task_id,
    input  logic [BURST_W-1:0]  i_burst_units,
    input  logic [PRIO_W-1:0]   i_priority_level,
    output logic                o_valid,
    input  logic                i_stall,
    output logic                o_served_valid,
    output logic [ID_W-1:0]     o_served_id,
    output logic [BURST_W-1:0]  o_served_remaining,
    output logic                o_served_done,
    output logic                o_arrival_dropped,
    output logic [WAIT_W-1:0]   o_tasks_waiting
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_FINISH = 2'd2;

    logic [1:0]         r_state;
    logic [1:0]         n_state;
    logic [CW-1:0]      r_scan;
    logic [CW-1:0]      r_count;
    logic [DEPTH-1:0]   r_slot_valid;
    logic               r_pvld;
    logic [AW-1:0]      r_pidx;
    logic               r_pend;
    logic [AW-1:0]      r_gone;
    logic               r_new_ok;
    logic [AW-1:0]      r_new_slot;
    logic               r_drop;

    logic               r_found;
    logic [AW-1:0]      r_bidx;
    t_task              r_best;
    logic [AW-1:0]      r_bage;

    logic               r_ov;
    logic               r_o_sv;
    logic [ID_W-1:0]    r_o_id;
    logic [BURST_W-1:0] r_o_rem;
    logic               r_o_done;
    logic               r_o_drop;
    logic [CW-1:0]      r_o_wait;

    t_task              task_mem [DEPTH];
    logic [AW-1:0]      age_mem  [DEPTH];
    t_task              r_task_rd;
    logic [AW-1:0]      r_age_rd;

    logic [AW-1:0]      free_idx;
    logic               full;
    logic               accept;
    logic               store;
    logic               finish_go;
    logic [AW-1:0]      rd_addr;
    logic               task_we;
    logic [AW-1:0]      task_waddr;
    t_task              task_wdata;
    logic               age_we;
    logic [AW-1:0]      age_waddr;
    logic [AW-1:0]      age_wdata;
    logic               ent_valid;
    logic               fix_age;
    logic [AW-1:0]      age_c;
    logic               better;
    logic [BURST_W-1:0] dec_burst;
    logic               done_now;
    logic [CW+WAIT_W-1:0] wait_ext;

    pps_free_find #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_free_find (
        .i_slot_valid (r_slot_valid),
        .o_free_idx   (free_idx),
        .o_full       (full)
    );

    assign o_stall   = (r_state != ST_IDLE);
    assign accept    = i_valid && (r_state == ST_IDLE);
    assign store     = accept && (i_burst_units != '0) && !full;
    assign finish_go = (r_state == ST_FINISH) && (!r_ov || !i_stall);
    assign rd_addr   = (r_scan < CW'(DEPTH)) ? r_scan[AW-1:0] : '0;

    assign ent_valid = r_pvld && r_slot_valid[r_pidx];
    assign fix_age   = ent_valid && r_pend && (r_age_rd > r_gone)
                       && !(r_new_ok && (r_pidx == r_new_slot));
    assign age_c     = fix_age ? (r_age_rd - AW'(1)) : r_age_rd;
    assign better    = ent_valid &&
                       (!r_found || (r_task_rd.prio < r_best.prio) ||
                        ((r_task_rd.prio == r_best.prio) && (age_c < r_bage)));
    assign dec_burst = r_best.burst - BURST_W'(1);
    assign done_now  = (dec_burst == '0);

    always_comb begin
        task_we    = 1'b0;
        task_waddr = free_idx;
        task_wdata = '{id: i_task_id, burst: i_burst_units, prio: i_priority_level};
        if (store) begin
            task_we = 1'b1;
        end else if (finish_go && r_found) begin
            task_we    = 1'b1;
            task_waddr = r_bidx;
            task_wdata = '{id: r_best.id, burst: dec_burst, prio: r_best.prio};
        end
    end

    always_comb begin
        age_we    = 1'b0;
        age_waddr = free_idx;
        age_wdata = r_count[AW-1:0];
        if (store) begin
            age_we = 1'b1;
        end else if (fix_age) begin
            age_we    = 1'b1;
            age_waddr = r_pidx;
            age_wdata = age_c;
        end
    end

    always_ff @(posedge i_clk) begin
        if (task_we) begin
            task_mem[task_waddr] <= task_wdata;
        end
        r_task_rd <= task_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (age_we) begin
            age_mem[age_waddr] <= age_wdata;
        end
        r_age_rd <= age_mem[rd_addr];
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (r_scan == CW'(DEPTH)) begin
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (finish_go) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_slot_valid <= '0;
            r_count      <= '0;
            r_pend       <= 1'b0;
            r_pvld       <= 1'b0;
            r_ov         <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pvld  <= (r_state == ST_SCAN) && (r_scan < CW'(DEPTH));
            if (store) begin
                r_slot_valid[free_idx] <= 1'b1;
                r_count                <= r_count + CW'(1);
            end
            if (finish_go) begin
                r_pend <= r_found && done_now;
                if (r_found && done_now) begin
                    r_slot_valid[r_bidx] <= 1'b0;
                    r_count              <= r_count - CW'(1);
                end
            end
            if (finish_go) begin
                r_ov <= 1'b1;
            end else if (r_ov && !i_stall) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_pidx <= rd_addr;
        if (accept) begin
            r_scan     <= '0;
            r_found    <= 1'b0;
            r_new_ok   <= store;
            r_new_slot <= free_idx;
            r_drop     <= (i_burst_units != '0) && full;
        end else if (r_state == ST_SCAN) begin
            r_scan <= r_scan + CW'(1);
        end
        if (better) begin
            r_found <= 1'b1;
            r_bidx  <= r_pidx;
            r_best  <= r_task_rd;
            r_bage  <= age_c;
        end
        if (finish_go) begin
            r_gone   <= r_bage;
            r_o_sv   <= r_found;
            r_o_id   <= r_found ? r_best.id : '0;
            r_o_rem  <= r_found ? dec_burst : '0;
            r_o_done <= r_found && done_now;
            r_o_drop <= r_drop;
            r_o_wait <= (r_found && done_now) ? (r_count - CW'(1)) : r_count;
        end
    end

    assign wait_ext = {{WAIT_W{1'b0}}, r_o_wait};

    assign o_valid            = r_ov;
    assign o_served_valid     = r_o_sv;
    assign o_served_id        = r_o_id;
    assign o_served_remaining = r_o_rem;
    assign o_served_done      = r_o_done;
    assign o_arrival_dropped  = r_o_drop;
    assign o_tasks_waiting    = wait_ext[WAIT_W-1:0];

endmodule

/* hw/rtl/pps_free_find.sv */
module pps_free_find
    import pps_pkg::*;
#(
    parameter int DEPTH = PPS_DEPTH,
    parameter int AW    = $clog2(PPS_DEPTH)
) (
    input  logic [DEPTH-1:0] i_slot_valid,
    output logic [AW-1:0]    o_free_idx,
    output logic             o_full
);

    always_comb begin
        o_free_idx = '0;
        for (int k = DEPTH - 1; k >= 0; k--) begin
            if (!i_slot_valid[k]) begin
                o_free_idx = AW'(k);
            end
        end
    end

    assign o_full = &i_slot_valid;

endmodule
